// File: hdl/two_queue_page_replacement_defines.svh
// Assertion macros shared by the page replacement tracker RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef TWO_QUEUE_PAGE_REPLACEMENT_DEFINES_SVH
`define TWO_QUEUE_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define TQPR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker assertion failed");

// Next-cycle implication, checked outside reset.
`define TQPR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");

`else

`define TQPR_ASSERT_IMPL(name, ante, cons)
`define TQPR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: hdl/tqpr_pkg.sv
// Types and codes for the two-queue page replacement tracker.
// No dependencies.
`timescale 1ns / 1ps

package tqpr_pkg;

    localparam int KIND_W   = 2;
    localparam int PAGE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int HIT_W    = 2;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [HIT_W-1:0]    hit_t;

    localparam kind_t KIND_ACCESS = 2'd0;
    localparam kind_t KIND_ERASE  = 2'd1;
    localparam kind_t KIND_EVICT  = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    localparam hit_t HIT_NEW      = 2'd0;
    localparam hit_t HIT_PROMOTED = 2'd1;
    localparam hit_t HIT_REFRESH  = 2'd2;
    localparam hit_t HIT_NONE     = 2'd3;

    localparam logic LIST_FIFO = 1'b0;
    localparam logic LIST_REC  = 1'b1;

endpackage

// File: hdl/two_queue_page_replacement.sv
// Two-queue page replacement tracker: first-use FIFO plus recency list.
//
// Request word (req_valid / req_stall): kind and page_id. kind 0 accesses a
// page, 1 erases it, 2 evicts one victim. Response word (rsp_valid /
// rsp_stall): victim_id, victim_valid, status, hit_class, is_empty; exactly
// one response per request, in order.
// Each list sits in its own slot memory; one sequencer with a single compare
// and address counter walks them, one slot per cycle for search and gap
// closing. The next request is taken in the cycle after the response loads.
// req_stall stays high from acceptance until the response is loaded into the
// output register, so one request is in flight at a time; a request can be
// accepted while the previous response still waits on rsp_stall.
// If the receiver stalls, the finished response holds the sequencer until
// the output register frees up. Reset empties both lists (fill counts go to
// zero) and clears the output valid; slot contents are not cleared.
`timescale 1ns / 1ps

module two_queue_page_replacement #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tqpr_pkg::kind_t   kind,
    input  tqpr_pkg::page_t   page_id,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tqpr_pkg::page_t   victim_id,
    output logic              victim_valid,
    output tqpr_pkg::status_t status,
    output tqpr_pkg::hit_t    hit_class,
    output logic              is_empty
);

    import tqpr_pkg::*;

    `include "two_queue_page_replacement_defines.svh"

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int MAX_W  = (ID_BITS > PAGE_W) ? ID_BITS : PAGE_W;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W:0]   CAP_CNT  = (CNT_W + 1)'(CAPACITY);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_VREAD = 3'd3;
    localparam logic [2:0] ST_VCAP  = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]         state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic               sel_reg, sel_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   fifo_fill_reg, fifo_fill_next;
    logic [CNT_W-1:0]   rec_fill_reg, rec_fill_next;
    logic [ID_BITS-1:0] victim_reg, victim_next;
    logic               vvalid_reg, vvalid_next;
    status_t            status_reg, status_next;
    hit_t               hit_reg, hit_next;

    logic               rsp_valid_reg, rsp_valid_next;
    page_t              victim_out_reg, victim_out_next;
    logic               vvalid_out_reg, vvalid_out_next;
    status_t            status_out_reg, status_out_next;
    hit_t               hit_out_reg, hit_out_next;
    logic               empty_out_reg, empty_out_next;

    logic [MAX_W-1:0]   page_wide;
    logic [MAX_W-1:0]   victim_wide;
    logic [ID_BITS-1:0] page_masked;
    logic [CNT_W-1:0]   cur_fill;
    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W:0]     total_fill;
    logic [ID_BITS-1:0] fifo_rd, rec_rd, rd_data;
    logic               match;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic               wr_en;

    assign page_wide   = MAX_W'(page_id);
    assign page_masked = page_wide[ID_BITS-1:0];
    assign victim_wide = MAX_W'(victim_reg);

    assign cur_fill   = (sel_reg == LIST_REC) ? rec_fill_reg : fifo_fill_reg;
    assign idx_dec    = idx_reg - CNT_ONE;
    assign total_fill = (CNT_W + 1)'(fifo_fill_reg) + (CNT_W + 1)'(rec_fill_reg);
    assign rd_data    = (sel_reg == LIST_REC) ? rec_rd : fifo_rd;
    assign match      = pend_reg && (rd_data == id_reg);

    tqpr_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ID_BITS)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (wr_en && (sel_reg == LIST_FIFO)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (fifo_rd)
    );

    tqpr_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ID_BITS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en && (sel_reg == LIST_REC)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rec_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        sel_next        = sel_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_next       = pend_reg;
        fifo_fill_next  = fifo_fill_reg;
        rec_fill_next   = rec_fill_reg;
        victim_next     = victim_reg;
        vvalid_next     = vvalid_reg;
        status_next     = status_reg;
        hit_next        = hit_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        victim_out_next = victim_out_reg;
        vvalid_out_next = vvalid_out_reg;
        status_out_next = status_out_reg;
        hit_out_next    = hit_out_reg;
        empty_out_next  = empty_out_reg;
        rd_addr         = idx_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = cmp_idx_reg;
        wr_data         = rd_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next   = kind;
                    id_next     = page_masked;
                    victim_next = '0;
                    vvalid_next = 1'b0;
                    status_next = STATUS_OK;
                    hit_next    = HIT_NONE;
                    pend_next   = 1'b0;
                    idx_next    = '0;
                    case (kind)
                        KIND_ACCESS, KIND_ERASE:
                        begin
                            sel_next   = LIST_REC;
                            state_next = ST_SCAN;
                        end
                        KIND_EVICT:
                        begin
                            if (fifo_fill_reg != '0)
                            begin
                                sel_next   = LIST_FIFO;
                                state_next = ST_VREAD;
                            end
                            else if (rec_fill_reg != '0)
                            begin
                                sel_next   = LIST_REC;
                                state_next = ST_VREAD;
                            end
                            else
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    // close the gap starting just above the hit
                    idx_next   = CNT_W'(cmp_idx_reg) + CNT_ONE;
                    pend_next  = 1'b0;
                    state_next = ST_SHIFT;
                end
                else if (idx_reg < cur_fill)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + CNT_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    idx_next  = '0;
                    if (sel_reg == LIST_REC)
                    begin
                        sel_next = LIST_FIFO;
                    end
                    else if (kind_reg == KIND_ACCESS)
                    begin
                        if (total_fill >= CAP_CNT)
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            hit_next   = HIT_NEW;
                            state_next = ST_PUSH;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SHIFT:
            begin
                // drop the word read last cycle one slot lower
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (idx_reg < cur_fill)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_dec[ADDR_W-1:0];
                    idx_next     = idx_reg + CNT_ONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    idx_next  = '0;
                    if (sel_reg == LIST_REC)
                    begin
                        rec_fill_next = rec_fill_reg - CNT_ONE;
                    end
                    else
                    begin
                        fifo_fill_next = fifo_fill_reg - CNT_ONE;
                    end
                    case (kind_reg)
                        KIND_ACCESS:
                        begin
                            hit_next   = (sel_reg == LIST_REC) ? HIT_REFRESH : HIT_PROMOTED;
                            sel_next   = LIST_REC;
                            state_next = ST_PUSH;
                        end
                        KIND_ERASE:
                        begin
                            if (sel_reg == LIST_REC)
                            begin
                                sel_next   = LIST_FIFO;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_VREAD:
            begin
                rd_addr    = '0;
                state_next = ST_VCAP;
            end

            ST_VCAP:
            begin
                victim_next = rd_data;
                vvalid_next = 1'b1;
                idx_next    = CNT_ONE;
                pend_next   = 1'b0;
                state_next  = ST_SHIFT;
            end

            ST_PUSH:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_fill[ADDR_W-1:0];
                wr_data = id_reg;
                if (sel_reg == LIST_REC)
                begin
                    rec_fill_next = rec_fill_reg + CNT_ONE;
                end
                else
                begin
                    fifo_fill_next = fifo_fill_reg + CNT_ONE;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    victim_out_next = victim_wide[PAGE_W-1:0];
                    vvalid_out_next = vvalid_reg;
                    status_out_next = status_reg;
                    hit_out_next    = hit_reg;
                    empty_out_next  = (fifo_fill_reg == '0) && (rec_fill_reg == '0);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            fifo_fill_reg <= '0;
            rec_fill_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            fifo_fill_reg <= fifo_fill_next;
            rec_fill_reg  <= rec_fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        sel_reg        <= sel_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        victim_reg     <= victim_next;
        vvalid_reg     <= vvalid_next;
        status_reg     <= status_next;
        hit_reg        <= hit_next;
        victim_out_reg <= victim_out_next;
        vvalid_out_reg <= vvalid_out_next;
        status_out_reg <= status_out_next;
        hit_out_reg    <= hit_out_next;
        empty_out_reg  <= empty_out_next;
    end

    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign victim_id    = victim_out_reg;
    assign victim_valid = vvalid_out_reg;
    assign status       = status_out_reg;
    assign hit_class    = hit_out_reg;
    assign is_empty     = empty_out_reg;

    `TQPR_ASSERT_IMPL(a_fill_in_capacity, 1'b1, total_fill <= CAP_CNT)
    `TQPR_ASSERT_NEXT(a_accept_goes_busy, req_valid && !req_stall, state_reg != ST_IDLE)
    `TQPR_ASSERT_IMPL(a_pending_in_range, pend_reg, CNT_W'(cmp_idx_reg) < cur_fill)
    `TQPR_ASSERT_IMPL(a_victim_clean, rsp_valid && victim_valid,
                      (status == STATUS_OK) && (hit_class == HIT_NONE) && !is_empty
                      || (status == STATUS_OK) && (hit_class == HIT_NONE) && is_empty)

endmodule

// File: hdl/tqpr_ram.sv
// Page slot memory: one write port, one read port with registered data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module tqpr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
